@@ design/esd_pkg.sv @@
// shared item and queue entry types for the escape sequence decoder
`timescale 1ns / 1ps

package esd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic       failed;
  } out_item_t;

  // work left for the back end by one input item: a decoded byte, an end mark, or both
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       has_end;
    logic       end_failed;
  } cmd_t;

endpackage

@@ design/escape_sequence_decoder.sv @@
// top level of the escape sequence decoder
`timescale 1ns / 1ps

// Decodes C-style backslash escapes from a byte stream. One input item (a raw
// byte plus an end-of-string flag) can be taken every cycle while the command
// queue is not full; the mode machine in the front end decides each item in
// the cycle it is accepted. Results leave at one per cycle while out_ready is
// high, from a registered output, so an item with a decoded byte and end mark
// gives two results; the QUEUE_DEPTH-entry command queue ahead of the output
// register absorbs such bursts and output stalls. After a failed end mark the
// caller drops the bytes already delivered for that string.
module escape_sequence_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  esd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output esd_pkg::out_item_t out_item
);
  import esd_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic q_valid;
  cmd_t head;
  logic second_r;

  esd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .second_r  (second_r)
  );

  // the last byte of a string always leaves a command behind
  a_eos_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.end_of_string |-> push)
    else $error("end of string accepted without a command");

  // a byte result never carries a failure
  a_byte_not_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.is_end |-> !out_item.failed)
    else $error("decoded byte marked failed");

  // the pending end mark waits on a command still at the queue head
  a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> q_valid && head.has_end && head.has_byte)
    else $error("end mark pending without its command");

  // a byte result followed by the end mark of the same command
  a_second_follows_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(second_r) |-> out_valid && !out_item.is_end)
    else $error("pending end mark without a byte before it");

endmodule

@@ design/esd_front.sv @@
// front end: accepts raw bytes, runs the escape mode machine, emits result commands
`timescale 1ns / 1ps

module esd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  esd_pkg::in_item_t in_item,
  output logic             push,
  output esd_pkg::cmd_t    push_cmd,
  input  logic             q_full
);
  import esd_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX_HI = 2'd2,
    MODE_HEX_LO = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // {valid, value} of one hex digit in either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic       disc_r, disc_nxt;
  logic       fail;
  logic       have;
  logic [7:0] b;
  logic [4:0] hx;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_digit(in_item.in_byte);

  always_comb begin
    fail     = 1'b0;
    have     = 1'b0;
    b        = 8'd0;
    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    disc_nxt = disc_r;
    if (disc_r) begin
      fail = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_TEXT: begin
          if (in_item.in_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            b    = in_item.in_byte;
            have = 1'b1;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_TEXT;
          have     = 1'b1;
          unique case (in_item.in_byte)
            CH_N:      b = CH_LF;
            CH_T:      b = CH_TAB;
            CH_R:      b = CH_CR;
            CH_ZERO:   b = CH_NUL;
            CH_BSLASH: b = CH_BSLASH;
            CH_SQUOTE: b = CH_SQUOTE;
            CH_DQUOTE: b = CH_DQUOTE;
            CH_X: begin
              have     = 1'b0;
              mode_nxt = MODE_HEX_HI;
            end
            default: begin
              have = 1'b0;
              fail = 1'b1;
            end
          endcase
        end
        MODE_HEX_HI: begin
          if (!hx[4]) begin
            fail     = 1'b1;
            mode_nxt = MODE_TEXT;
          end else begin
            nib_nxt  = hx[3:0];
            mode_nxt = MODE_HEX_LO;
          end
        end
        MODE_HEX_LO: begin
          mode_nxt = MODE_TEXT;
          if (!hx[4]) begin
            fail = 1'b1;
          end else begin
            b    = {nib_r, hx[3:0]};
            have = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_TEXT;
        end
      endcase
    end
    if (fail) begin
      have     = 1'b0;
      mode_nxt = MODE_TEXT;
      disc_nxt = 1'b1;
    end
    push_cmd.has_byte   = have;
    push_cmd.data       = b;
    push_cmd.has_end    = in_item.end_of_string;
    // an escape still open at the last byte counts as cut off
    push_cmd.end_failed = fail || (mode_nxt != MODE_TEXT);
    if (in_item.end_of_string) begin
      mode_nxt = MODE_TEXT;
      nib_nxt  = 4'd0;
      disc_nxt = 1'b0;
    end
  end

  assign push = accept && (have || in_item.end_of_string);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      nib_r  <= 4'd0;
      disc_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

@@ design/esd_queue.sv @@
// small command queue between the front and back ends
`timescale 1ns / 1ps

module esd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  esd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output esd_pkg::cmd_t head
);
  import esd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          slots_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign q_valid = (cnt_r != '0);
  assign head    = slots_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push_cmd;
    end
  end

endmodule

@@ design/esd_back.sv @@
// back end: expands queued commands into result items behind an output register
`timescale 1ns / 1ps

module esd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  esd_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output esd_pkg::out_item_t out_item,
  output logic               second_r
);
  import esd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      second_nxt;
  logic      load;

  assign load = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    second_nxt    = second_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (head.has_byte && !second_r) begin
        out_item_nxt = '{out_byte: head.data, is_end: 1'b0, failed: 1'b0};
        // byte first, end mark on the next slot
        if (head.has_end) begin
          second_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_item_nxt = '{out_byte: 8'd0, is_end: 1'b1, failed: head.end_failed};
        second_nxt   = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ tb/sv/escape_sequence_decoder_tb.sv @@
// self-checking testbench for the escape sequence decoder
`timescale 1ns / 1ps

module escape_sequence_decoder_tb;
  import esd_pkg::*;

  typedef enum logic [1:0] {
    M_TEXT,
    M_ESC,
    M_HEX_HI,
    M_HEX_LO
  } dec_mode_e;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_X      = "x";
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [55:0] ESC_LETTERS =
    {CH_N, CH_T, CH_R, CH_ZERO, CH_BSLASH, CH_SQUOTE, CH_DQUOTE};

  localparam int HOLD_LEN     = 60;
  localparam int RANDOM_ITEMS = 1000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // predictor state
  dec_mode_e  dec_mode = M_TEXT;
  logic [3:0] dec_nibble = '0;
  logic       dec_discarding = 1'b0;
  out_item_t  decoded_q[$];

  int errors = 0;
  int items_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  int failed_ends = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  escape_sequence_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // bit 4 flags a valid hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(int v, int upper);
    if (v < 10) return 8'("0" + v);
    return (upper != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    logic [4:0] hv;
    do begin
      b = 8'($urandom_range(0, 255));
      hv = hex_of(b);
    end while (hv[4]);
    return b;
  endfunction

  task automatic push_result(logic [7:0] b, logic is_end, logic failed);
    out_item_t r;
    r.out_byte = b;
    r.is_end   = is_end;
    r.failed   = failed;
    decoded_q.push_back(r);
  endtask

  // advance the decoder state by one accepted item and queue what it yields
  task automatic decode_step(in_item_t it);
    logic [4:0] hv;
    logic       fail;
    logic       have;
    logic [7:0] b;
    hv = hex_of(it.in_byte);
    fail = 1'b0;
    have = 1'b0;
    b = '0;
    if (dec_discarding) begin
      fail = 1'b1;
    end else begin
      case (dec_mode)
        M_TEXT: begin
          if (it.in_byte == CH_BSLASH) dec_mode = M_ESC;
          else begin
            b = it.in_byte;
            have = 1'b1;
          end
        end
        M_ESC: begin
          dec_mode = M_TEXT;
          have = 1'b1;
          case (it.in_byte)
            CH_N:      b = BYTE_LF;
            CH_T:      b = BYTE_TAB;
            CH_R:      b = BYTE_CR;
            CH_ZERO:   b = BYTE_NUL;
            CH_BSLASH: b = CH_BSLASH;
            CH_SQUOTE: b = CH_SQUOTE;
            CH_DQUOTE: b = CH_DQUOTE;
            CH_X: begin
              have = 1'b0;
              dec_mode = M_HEX_HI;
            end
            default: begin
              have = 1'b0;
              fail = 1'b1;
            end
          endcase
        end
        M_HEX_HI: begin
          if (!hv[4]) fail = 1'b1;
          else begin
            dec_nibble = hv[3:0];
            dec_mode = M_HEX_LO;
          end
        end
        default: begin
          dec_mode = M_TEXT;
          if (!hv[4]) fail = 1'b1;
          else begin
            b = {dec_nibble, hv[3:0]};
            have = 1'b1;
          end
        end
      endcase
    end
    if (fail) begin
      have = 1'b0;
      dec_mode = M_TEXT;
      dec_discarding = 1'b1;
    end
    if (have) push_result(b, 1'b0, 1'b0);
    if (it.end_of_string) begin
      // an escape still open at the end is cut off
      if (!fail && dec_mode != M_TEXT) fail = 1'b1;
      push_result(8'h00, 1'b1, fail);
      dec_mode = M_TEXT;
      dec_nibble = '0;
      dec_discarding = 1'b0;
    end
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(logic [7:0] b, logic eos);
    int gap;
    in_item_t it;
    gap = tx_idle ? pick_gap() : 0;
    it.in_byte = b;
    it.end_of_string = eos;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    decode_step(it);
    items_sent++;
  endtask

  task automatic send_string(byte_q_t s);
    foreach (s[i]) send_item(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  // valid must drop before anything that lets time pass between items
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained(int limit);
    int n;
    n = 0;
    while (decoded_q.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      errors++;
    end
  endtask

  // mostly well-formed escapes with random content, some broken ones
  task automatic send_random_string(int max_tokens);
    byte_q_t s;
    int n;
    int k;
    logic [7:0] b;
    bit cut;
    n = $urandom_range(1, max_tokens);
    cut = 1'b0;
    for (int i = 0; i < n && !cut; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        b = 8'($urandom_range(0, 255));
        s.push_back(b);
        if (b == CH_BSLASH) s.push_back(CH_BSLASH);
      end else if (k < 68) begin
        s.push_back(CH_BSLASH);
        s.push_back(ESC_LETTERS[8 * $urandom_range(0, 6) +: 8]);
      end else if (k < 88) begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_X);
        s.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
        s.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
      end else begin
        s.push_back(CH_BSLASH);
        case ($urandom_range(0, 3))
          0: begin
            do b = 8'($urandom_range(0, 255));
            while (b inside {CH_N, CH_T, CH_R, CH_ZERO, CH_BSLASH, CH_SQUOTE, CH_DQUOTE,
                             CH_X});
            s.push_back(b);
          end
          1: begin
            s.push_back(CH_X);
            s.push_back(non_hex());
          end
          2: begin
            s.push_back(CH_X);
            s.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            s.push_back(non_hex());
          end
          default: begin
            // escape cut off by the end of the string
            k = $urandom_range(0, 2);
            if (k > 0) s.push_back(CH_X);
            if (k > 1) s.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            cut = 1'b1;
          end
        endcase
      end
    end
    send_string(s);
  endtask

  task automatic test_escapes();
    send_string('{8'h00, 8'hFF, CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_R,
                  CH_BSLASH, CH_ZERO, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SQUOTE,
                  CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_X, "a", "F"});
    idle_input();
  endtask

  task automatic test_failures();
    send_string('{CH_BSLASH, "q", "z"});       // unknown escape, rest swallowed
    send_string('{CH_BSLASH});                 // cut off after backslash
    send_string('{CH_BSLASH, CH_X});           // cut off after x
    send_string('{CH_BSLASH, CH_X, "4"});      // cut off after first digit
    idle_input();
  endtask

  task automatic test_backpressure();
    int start;
    start = items_sent;
    tx_idle = 1'b0;
    @(negedge clk);
    hold_seq++;
    @(posedge clk);
    while (items_sent - start < 40) send_random_string(6);
    idle_input();
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_random_string(6);
    idle_input();
    wait_drained(2000);
    send_random_string(6);
    idle_input();
  endtask

  task automatic test_random();
    int start;
    int done;
    start = items_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // a stretch in the middle runs with no idling on either side
      tx_idle = !(done >= 400 && done < 600);
      rx_idle = tx_idle;
      send_random_string(($urandom_range(0, 15) == 0) ? 24 : 6);
      if ($urandom_range(0, 39) == 0) begin
        idle_input();
        wait_drained(2000);
      end
      done = items_sent - start;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    idle_input();
  endtask

  // receiver: long hold on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  task automatic report_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  // outputs are stable at the falling edge; valid and ready here mean a take at the next rise
  always @(negedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_item.is_end && out_item.failed) failed_ends++;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result byte %0h end %0b failed %0b", $time,
                 out_item.out_byte, out_item.is_end, out_item.failed);
        errors++;
      end else begin
        exp_r = decoded_q.pop_front();
        report_field("out_byte", exp_r.out_byte, out_item.out_byte);
        report_field("is_end", exp_r.is_end, out_item.is_end);
        report_field("failed", exp_r.failed, out_item.failed);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escapes();
    test_failures();
    test_backpressure();
    test_drain_pause();
    test_random();
    wait_drained(5000);
    repeat (10) @(posedge clk);
    $display("sent %0d items in %0d strings under random stalls and a long output hold",
             items_sent, strings_sent);
    $display("checked %0d results, %0d of them failed end marks", results_seen, failed_ends);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", decoded_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ escape_sequence_decoder.f @@
design/esd_pkg.sv
design/esd_front.sv
design/esd_queue.sv
design/esd_back.sv
design/escape_sequence_decoder.sv
tb/sv/escape_sequence_decoder_tb.sv
